>>> hdl/okin_pkg.sv
package okin_pkg;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 18;
  localparam int LIM_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  // divider geometry: numerator magnitude, divisor, quotient bits
  localparam int NUM_W   = 54;
  localparam int DEN_W   = 38;
  localparam int QW      = 36;
  localparam int DIV_LAT = QW + 1;

  // mixer widths
  localparam int W_W    = QW + 3;
  localparam int PROD_W = 56;
  localparam int ACC_W  = 58;
  localparam int FRAC_W = 16;

  localparam logic [24:0] VEL_K = 25'd24000000;
  localparam logic [16:0] MIX_K = 17'd46341;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_KIND = 2'd0,
    CFG_CIRC      = 2'd1,
    CFG_TRACK     = 2'd2,
    CFG_MAX_SPEED = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SC_NONE = 2'd0,
    SC_XY   = 2'd1,
    SC_XT   = 2'd2
  } scale_e;

  typedef struct packed {
    logic [NUM_W-1:0] nx;
    logic             neg_x;
    logic [NUM_W-1:0] ny;
    logic             neg_y;
    logic [NUM_W-1:0] nt;
    logic             neg_t;
    logic [DEN_W-1:0] den;
    logic             yaw0;
    logic             vy0;
    logic [LIM_W-1:0] lim;
  } item_t;

  typedef struct packed {
    logic             yaw0;
    logic             vy0;
    logic [LIM_W-1:0] lim;
  } sb_t;

  typedef struct packed {
    logic [QW-1:0]    xm;
    logic [QW-1:0]    ym;
    logic [QW-1:0]    tm;
    logic             xn;
    logic             yn;
    logic             tn;
    scale_e           mode;
    logic [LIM_W-1:0] lim;
  } axes_t;

  function automatic logic signed [W_W-1:0] to_signed(input logic [QW-1:0] mag,
                                                      input logic neg);
    logic signed [W_W-1:0] v;
    v = $signed(W_W'(mag));
    return neg ? -v : v;
  endfunction

endpackage

>>> hdl/omni_wheel_inverse_kinematics.sv
// Path: an accepted command passes through two bit-per-stage divider pipelines
// plus scale and mix stages; the back end reads the queue in the cycle after
// the push.
// Throughput: one command per cycle; every stage advances each cycle since
// the receiver cannot stall, so busy stays low in operation.
// Reset: asynchronous, active low; clears pipeline valids and the queue and
// loads the register defaults (omni base, 314150 um, 300000 um, 4800).
module omni_wheel_inverse_kinematics (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we_i,
  input  logic [okin_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [okin_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [okin_pkg::IN_W-1:0]       vel_x_mm_s_i,
  input  logic [okin_pkg::IN_W-1:0]       vel_y_mm_s_i,
  input  logic [okin_pkg::IN_W-1:0]       yaw_rate_mrad_s_i,
  output logic                           done_o,
  output logic [okin_pkg::OUT_W-1:0]      wheel1_rpm_q4_o,
  output logic [okin_pkg::OUT_W-1:0]      wheel2_rpm_q4_o,
  output logic [okin_pkg::OUT_W-1:0]      wheel3_rpm_q4_o,
  output logic [okin_pkg::OUT_W-1:0]      wheel4_rpm_q4_o
);
  import okin_pkg::*;

  logic  push, full, empty;
  item_t fr_item, q_item;

  okin_front u_front (
    .clk_i, .rst_ni,
    .accept_i          (start && !busy),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .vel_x_mm_s_i, .vel_y_mm_s_i, .yaw_rate_mrad_s_i,
    .push_o            (push),
    .item_o            (fr_item)
  );

  okin_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (fr_item),
    .pop_i   (!empty),
    .data_o  (q_item),
    .full_o  (full),
    .empty_o (empty)
  );

  okin_back u_back (
    .clk_i, .rst_ni,
    .valid_i (!empty),
    .item_i  (q_item),
    .done_o,
    .wheel1_rpm_q4_o, .wheel2_rpm_q4_o, .wheel3_rpm_q4_o, .wheel4_rpm_q4_o
  );

  assign busy = full;

endmodule

>>> hdl/okin_div.sv
module okin_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [okin_pkg::NUM_W-1:0] mag_i,
  input  logic [okin_pkg::DEN_W-1:0] den_i,
  input  logic                      neg_i,
  output logic                      valid_o,
  output logic [okin_pkg::QW-1:0]    quo_o,
  output logic                      neg_o
);
  import okin_pkg::*;

  localparam int CMP_W = DEN_W + QW;

  logic [NUM_W-1:0] rem_q [QW+1];
  logic [DEN_W-1:0] den_q [QW+1];
  logic [QW-1:0]    quo_q [QW+1];
  logic             neg_q [QW+1];
  logic             vld_q [QW+1];

  // round half away: bias the magnitude by half the divisor up front
  always_ff @(posedge clk_i) begin
    rem_q[0] <= mag_i + NUM_W'(den_i >> 1);
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    neg_q[0] <= neg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int Bit = QW - 1 - g;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] den_sh;
    logic             ge;

    always_comb begin
      rem_ext = CMP_W'(rem_q[g]);
      den_sh  = CMP_W'(den_q[g]) << Bit;
      ge      = rem_ext >= den_sh;
    end

    always_ff @(posedge clk_i) begin
      rem_q[g+1] <= ge ? NUM_W'(rem_ext - den_sh) : rem_q[g];
      den_q[g+1] <= den_q[g];
      quo_q[g+1] <= quo_q[g] | (QW'(ge) << Bit);
      neg_q[g+1] <= neg_q[g];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign neg_o   = neg_q[QW];

endmodule

>>> hdl/okin_front.sv
module okin_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           cfg_we_i,
  input  logic [okin_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [okin_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [okin_pkg::IN_W-1:0]       vel_x_mm_s_i,
  input  logic [okin_pkg::IN_W-1:0]       vel_y_mm_s_i,
  input  logic [okin_pkg::IN_W-1:0]       yaw_rate_mrad_s_i,
  output logic                           push_o,
  output okin_pkg::item_t                item_o
);
  import okin_pkg::*;

  logic [1:0]       base_q;
  logic [19:0]      circ_q;
  logic [21:0]      track_q;
  logic [LIM_W-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 2'd2;
      circ_q  <= 20'd314150;
      track_q <= 22'd300000;
      lim_q   <= 17'd4800;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_KIND: base_q  <= cfg_data_i[1:0];
        CFG_CIRC:      circ_q  <= cfg_data_i[19:0];
        CFG_TRACK:     track_q <= cfg_data_i[21:0];
        CFG_MAX_SPEED: lim_q   <= cfg_data_i[LIM_W-1:0];
        default:       ;
      endcase
    end
  end

  logic [IN_W-1:0] vy;
  logic [IN_W:0]   ax, ay_v, at;
  logic [20:0]     yaw12;
  logic [19:0]     circ_e;

  always_comb begin
    // differential and skid bases have no sideways axis
    vy     = base_q[1] ? vel_y_mm_s_i : '0;
    ax     = vel_x_mm_s_i[IN_W-1] ? ((IN_W+1)'(0) - {1'b1, vel_x_mm_s_i})
                                  : {1'b0, vel_x_mm_s_i};
    ay_v   = vy[IN_W-1] ? ((IN_W+1)'(0) - {1'b1, vy}) : {1'b0, vy};
    at     = yaw_rate_mrad_s_i[IN_W-1] ? ((IN_W+1)'(0) - {1'b1, yaw_rate_mrad_s_i})
                                       : {1'b0, yaw_rate_mrad_s_i};
    yaw12  = 21'({at, 3'b000}) + 21'({at, 2'b00});
    circ_e = (circ_q == '0) ? 20'd1 : circ_q;

    item_o.nx    = NUM_W'(42'(ax) * 42'(VEL_K));
    item_o.neg_x = vel_x_mm_s_i[IN_W-1];
    item_o.ny    = NUM_W'(42'(ay_v) * 42'(VEL_K));
    item_o.neg_y = vy[IN_W-1];
    item_o.nt    = NUM_W'(43'(yaw12) * 43'(track_q));
    item_o.neg_t = yaw_rate_mrad_s_i[IN_W-1];
    item_o.den   = DEN_W'({circ_e, 4'b0000}) + DEN_W'({circ_e, 3'b000}) + DEN_W'(circ_e);
    item_o.yaw0  = (yaw_rate_mrad_s_i == '0);
    item_o.vy0   = (vy == '0);
    item_o.lim   = lim_q;
    push_o       = accept_i;
  end

endmodule

>>> hdl/okin_fifo.sv
module okin_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  okin_pkg::item_t data_i,
  input  logic            pop_i,
  output okin_pkg::item_t data_o,
  output logic            full_o,
  output logic            empty_o
);
  import okin_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> hdl/okin_back.sv
module okin_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  okin_pkg::item_t          item_i,
  output logic                     done_o,
  output logic [okin_pkg::OUT_W-1:0] wheel1_rpm_q4_o,
  output logic [okin_pkg::OUT_W-1:0] wheel2_rpm_q4_o,
  output logic [okin_pkg::OUT_W-1:0] wheel3_rpm_q4_o,
  output logic [okin_pkg::OUT_W-1:0] wheel4_rpm_q4_o
);
  import okin_pkg::*;

  // ---- axis conversion dividers
  logic          d1_vld;
  logic [QW-1:0] xq, yq, tq;
  logic          xn, yn, tn;

  okin_div u_div_x (.clk_i, .rst_ni, .valid_i(valid_i), .mag_i(item_i.nx),
    .den_i(item_i.den), .neg_i(item_i.neg_x), .valid_o(d1_vld), .quo_o(xq), .neg_o(xn));
  okin_div u_div_y (.clk_i, .rst_ni, .valid_i(valid_i), .mag_i(item_i.ny),
    .den_i(item_i.den), .neg_i(item_i.neg_y), .valid_o(), .quo_o(yq), .neg_o(yn));
  okin_div u_div_t (.clk_i, .rst_ni, .valid_i(valid_i), .mag_i(item_i.nt),
    .den_i(item_i.den), .neg_i(item_i.neg_t), .valid_o(), .quo_o(tq), .neg_o(tn));

  sb_t sb1_q [DIV_LAT];
  always_ff @(posedge clk_i) begin
    sb1_q[0] <= '{yaw0: item_i.yaw0, vy0: item_i.vy0, lim: item_i.lim};
    for (int i = 1; i < DIV_LAT; i++) sb1_q[i] <= sb1_q[i-1];
  end

  // ---- scale decision
  sb_t         sb1;
  logic [QW:0] sxy, sxt;
  logic        cond_a, cond_b;
  scale_e      mode_b;

  always_comb begin
    sb1    = sb1_q[DIV_LAT-1];
    sxy    = {1'b0, xq} + {1'b0, yq};
    sxt    = {1'b0, xq} + {1'b0, tq};
    cond_a = (sxy >= (QW+1)'(sb1.lim)) && sb1.yaw0;
    cond_b = !cond_a && (sxt >= (QW+1)'(sb1.lim)) && sb1.vy0;
    priority if (cond_a && sxy != '0) mode_b = SC_XY;
    else if (cond_b && sxt != '0)     mode_b = SC_XT;
    else                              mode_b = SC_NONE;
  end

  axes_t       b_q;
  logic [QW:0] b_s_q;
  logic        v_b_q;

  always_ff @(posedge clk_i) begin
    b_q   <= '{xm: xq, ym: yq, tm: tq, xn: xn, yn: yn, tn: tn, mode: mode_b, lim: sb1.lim};
    b_s_q <= cond_a ? sxy : sxt;
  end

  // ---- scale products
  axes_t            c_q;
  logic [NUM_W-1:0] c_pa_q, c_pb_q;
  logic             c_nb_q;
  logic [QW:0]      c_s_q;
  logic             v_c_q;

  always_ff @(posedge clk_i) begin
    c_q    <= b_q;
    c_s_q  <= b_s_q;
    c_pa_q <= NUM_W'(NUM_W'(b_q.xm) * NUM_W'(b_q.lim));
    c_pb_q <= NUM_W'(NUM_W'((b_q.mode == SC_XY) ? b_q.ym : b_q.tm) * NUM_W'(b_q.lim));
    c_nb_q <= (b_q.mode == SC_XY) ? b_q.yn : b_q.tn;
  end

  logic          d2_vld;
  logic [QW-1:0] qa, qb;
  logic          qan, qbn;

  okin_div u_div_a (.clk_i, .rst_ni, .valid_i(v_c_q), .mag_i(c_pa_q),
    .den_i(DEN_W'(c_s_q)), .neg_i(c_q.xn), .valid_o(d2_vld), .quo_o(qa), .neg_o(qan));
  okin_div u_div_b (.clk_i, .rst_ni, .valid_i(v_c_q), .mag_i(c_pb_q),
    .den_i(DEN_W'(c_s_q)), .neg_i(c_nb_q), .valid_o(), .quo_o(qb), .neg_o(qbn));

  axes_t sb2_q [DIV_LAT];
  always_ff @(posedge clk_i) begin
    sb2_q[0] <= c_q;
    for (int i = 1; i < DIV_LAT; i++) sb2_q[i] <= sb2_q[i-1];
  end

  // ---- pick scaled or unscaled axes
  axes_t ax_d;
  always_comb begin
    ax_d = sb2_q[DIV_LAT-1];
    unique case (ax_d.mode)
      SC_XY: begin
        ax_d.xm = qa; ax_d.xn = qan;
        ax_d.ym = qb; ax_d.yn = qbn;
      end
      SC_XT: begin
        ax_d.xm = qa; ax_d.xn = qan;
        ax_d.tm = qb; ax_d.tn = qbn;
      end
      default: ;
    endcase
  end

  axes_t d_q;
  logic  v_d_q;
  always_ff @(posedge clk_i) d_q <= ax_d;

  // ---- omni mix
  logic signed [W_W-1:0]    xs, ys;
  logic signed [W_W-1:0]    w [4];
  logic signed [PROD_W-1:0] mixk;

  always_comb begin
    xs   = to_signed(d_q.xm, d_q.xn);
    ys   = to_signed(d_q.ym, d_q.yn);
    w[0] = -xs + ys;
    w[1] = -xs - ys;
    w[2] =  xs - ys;
    w[3] =  xs + ys;
    mixk = $signed(PROD_W'(MIX_K));
  end

  logic signed [PROD_W-1:0] e_m_q [4];
  logic signed [W_W-1:0]    e_t_q;
  logic [LIM_W-1:0]         e_lim_q;
  logic                     v_e_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) e_m_q[i] <= PROD_W'(w[i]) * mixk;
    e_t_q   <= to_signed(d_q.tm, d_q.tn);
    e_lim_q <= d_q.lim;
  end

  logic signed [ACC_W-1:0] f_acc_q [4];
  logic [LIM_W-1:0]        f_lim_q;
  logic                    v_f_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      f_acc_q[i] <= ACC_W'(e_m_q[i]) + (ACC_W'(e_t_q) <<< FRAC_W);
    end
    f_lim_q <= e_lim_q;
  end

  // ---- round, clamp
  logic [ACC_W-1:0]        mag  [4];
  logic [ACC_W-FRAC_W-1:0] q    [4];
  logic [LIM_W-1:0]        qc   [4];
  logic [OUT_W-1:0]        wout [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i]  = f_acc_q[i][ACC_W-1] ? ACC_W'(-f_acc_q[i]) : ACC_W'(f_acc_q[i]);
      q[i]    = (ACC_W-FRAC_W)'((mag[i] + (ACC_W'(1) << (FRAC_W-1))) >> FRAC_W);
      qc[i]   = (q[i] > (ACC_W-FRAC_W)'(f_lim_q)) ? f_lim_q : q[i][LIM_W-1:0];
      wout[i] = f_acc_q[i][ACC_W-1] ? (OUT_W'(0) - OUT_W'(qc[i])) : OUT_W'(qc[i]);
    end
  end

  logic [OUT_W-1:0] wheel_q [4];
  logic             done_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) wheel_q[i] <= wout[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_b_q  <= 1'b0;
      v_c_q  <= 1'b0;
      v_d_q  <= 1'b0;
      v_e_q  <= 1'b0;
      v_f_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v_b_q  <= d1_vld;
      v_c_q  <= v_b_q;
      v_d_q  <= d2_vld;
      v_e_q  <= v_d_q;
      v_f_q  <= v_e_q;
      done_q <= v_f_q;
    end
  end

  assign done_o          = done_q;
  assign wheel1_rpm_q4_o = wheel_q[0];
  assign wheel2_rpm_q4_o = wheel_q[1];
  assign wheel3_rpm_q4_o = wheel_q[2];
  assign wheel4_rpm_q4_o = wheel_q[3];

endmodule
